// File: design/cfcp_pkg.sv
// ----------------------------------------------------------------------------
// cfcp_pkg
// Shared types and constants for the framed command parser.
// ----------------------------------------------------------------------------
`default_nettype none
package cfcp_pkg;
    localparam int FRAME_BYTES_DEF = 32;
    localparam logic [31:0] POS_LIMIT = 32'h4348_0000;
    localparam logic [31:0] ACC_LIMIT = 32'h41A0_0000;
    localparam logic [31:0] ONE_BITS  = 32'h3F80_0000;
    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;

    localparam logic [1:0] REG_HDR_FIRST  = 2'd0;
    localparam logic [1:0] REG_HDR_SECOND = 2'd1;
    localparam logic [1:0] REG_VERSION    = 2'd2;
    localparam logic [1:0] REG_CMD_TYPE   = 2'd3;

    typedef struct packed {
        logic [7:0]  rx_byte;
        logic [31:0] arrival_ms;
    } t_in;

    typedef struct packed {
        logic        frame_valid;
        logic [31:0] sequence_no;
        logic [31:0] capture_us;
        logic [31:0] ball_position_bits;
        logic [31:0] confidence_bits;
        logic [31:0] target_position_bits;
        logic [31:0] acceleration_bits;
        logic [7:0]  task_code;
        logic [7:0]  flag_bits;
        logic [31:0] frame_arrival_ms;
        logic [31:0] good_count;
        logic [31:0] bad_count;
    } t_out;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] v);
        logic [15:0] c;
        c = crc ^ {v, 8'h00};
        for (int b = 0; b < 8; b++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction
endpackage
`default_nettype wire

// File: design/cfcp_ram.sv
// ----------------------------------------------------------------------------
// cfcp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module cfcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: design/crc_framed_command_parser_top.sv
// ----------------------------------------------------------------------------
// crc_framed_command_parser_top
// Header hunt, 32-byte frame capture, CRC and field check, resync.
// ----------------------------------------------------------------------------
// Input beat: one received byte plus timestamp (i_in_valid / o_in_stall).
// Output beat: one result per input byte (o_out_valid / i_out_stall).
// Config: i_cfg_valid / o_cfg_ready, index and 8-bit data, taken any time.
// A byte that does not complete a frame goes through the S_OUT state to the
// output register; the next byte is taken the cycle after the result leaves.
// On the 32nd byte a sequencer sweeps the stored frame through
// the one RAM read port: one byte a cycle for CRC and field unpack, and on
// rejection a header search plus a byte-by-byte move of the tail to the
// front. Only one byte is in work.
// The result is held in an output register; while i_out_stall is high the
// block waits with that beat and takes no new byte.
// Synchronous active-low reset clears fill level, counters, config registers,
// the output valid flag and the sequencer; the frame RAM is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module crc_framed_command_parser_top #(
    parameter int FRAME_BYTES = cfcp_pkg::FRAME_BYTES_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_stall,
    input  wire cfcp_pkg::t_in  i_in,
    output logic              o_out_valid,
    input  wire               i_out_stall,
    output cfcp_pkg::t_out    o_out,
    input  wire               i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire [1:0]         i_cfg_index,
    input  wire [7:0]         i_cfg_data
);
    import cfcp_pkg::*;

    localparam int AW = $clog2(FRAME_BYTES);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CHK   = 9'b000000010,
        S_FIN   = 9'b000000100,
        S_SRCH  = 9'b000001000,
        S_SRCH2 = 9'b000010000,
        S_MOVE  = 9'b000100000,
        S_MOVE2 = 9'b001000000,
        S_OUT   = 9'b010000000,
        S_WAIT  = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic [7:0] r_hf, r_hs, r_ver, r_cmd;
    logic [AW:0] r_fill, n_fill;
    logic [31:0] r_good, n_good, r_bad, n_bad;
    logic [AW:0] r_idx, n_idx;
    logic [AW:0] r_src, n_src;
    logic [AW:0] r_dst, n_dst;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_prev, n_prev;
    logic        r_ok, n_ok;
    logic [31:0] r_ms, n_ms;
    t_out        r_out, n_out;
    logic        r_ov, n_ov;
    logic [31:0] r_word, n_word;

    logic         we;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]   wdata, rdata;

    cfcp_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE) || r_ov;
    assign o_out_valid = r_ov;
    assign o_out       = r_out;

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    // byte position of the read data of the previous cycle
    logic [AW:0] rpos;
    assign rpos = r_idx - 1'b1;

    function automatic logic sym_ok(input logic [31:0] raw, input logic [31:0] lim);
        return {1'b0, raw[30:0]} <= lim;
    endfunction

    always_comb begin
        n_state = r_state;
        n_fill = r_fill; n_good = r_good; n_bad = r_bad;
        n_idx = r_idx; n_src = r_src; n_dst = r_dst;
        n_crc = r_crc; n_prev = r_prev; n_ok = r_ok; n_ms = r_ms;
        n_out = r_out; n_ov = r_ov; n_word = r_word;
        we = 1'b0; waddr = '0; wdata = '0; raddr = r_idx[AW-1:0];
        if (r_ov && !i_out_stall) n_ov = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_ms = i_in.arrival_ms;
                    n_out = '0;
                    n_state = S_OUT;
                    if (r_fill == '0) begin
                        if (i_in.rx_byte == r_hf) begin
                            we = 1'b1; waddr = '0; wdata = i_in.rx_byte;
                            n_fill = (AW+1)'(1);
                        end
                    end else if (r_fill == 1) begin
                        if (i_in.rx_byte == r_hs) begin
                            we = 1'b1; waddr = AW'(1); wdata = i_in.rx_byte;
                            n_fill = (AW+1)'(2);
                        end else if (i_in.rx_byte == r_hf) begin
                            we = 1'b1; waddr = '0; wdata = i_in.rx_byte;
                        end else begin
                            n_fill = '0;
                        end
                    end else begin
                        we = 1'b1; waddr = r_fill[AW-1:0]; wdata = i_in.rx_byte;
                        n_fill = r_fill + 1'b1;
                        if (r_fill == (AW+1)'(FRAME_BYTES - 1)) begin
                            n_state = S_CHK;
                            n_idx = '0;
                            n_crc = CRC_INIT;
                            n_ok = 1'b1;
                        end
                    end
                end
            end
            S_CHK: begin
                // read address r_idx issued; data of rpos arrives
                raddr = r_idx[AW-1:0];
                if (r_idx != '0) begin
                    if (rpos == 0 && rdata != r_hf) n_ok = 1'b0;
                    if (rpos == 1 && rdata != r_hs) n_ok = 1'b0;
                    if (rpos == 2 && rdata != r_ver) n_ok = 1'b0;
                    if (rpos == 3 && rdata != r_cmd) n_ok = 1'b0;
                    if (rpos >= 2 && rpos < 30) n_crc = crc_byte(r_crc, rdata);
                    if (rpos == 31 && {rdata, r_prev} != r_crc) n_ok = 1'b0;
                    n_prev = rdata;
                    n_word = {rdata, r_word[31:8]};
                    if (rpos[1:0] == 2'd3) begin
                        case (rpos[AW:2])
                            1: n_out.sequence_no = n_word;
                            2: n_out.capture_us = n_word;
                            3: begin
                                n_out.ball_position_bits = n_word;
                                if (!sym_ok(n_word, POS_LIMIT)) n_ok = 1'b0;
                            end
                            4: begin
                                n_out.confidence_bits = n_word;
                                if (!(n_word == 32'h8000_0000 ||
                                      (!n_word[31] && n_word <= ONE_BITS))) n_ok = 1'b0;
                            end
                            5: begin
                                n_out.target_position_bits = n_word;
                                if (!sym_ok(n_word, POS_LIMIT)) n_ok = 1'b0;
                            end
                            6: begin
                                n_out.acceleration_bits = n_word;
                                if (!sym_ok(n_word, ACC_LIMIT)) n_ok = 1'b0;
                            end
                            7: begin
                                n_out.task_code = n_word[7:0];
                                n_out.flag_bits = n_word[15:8];
                            end
                            default: ;
                        endcase
                    end
                end
                if (r_idx == (AW+1)'(FRAME_BYTES)) n_state = S_FIN;
                else n_idx = r_idx + 1'b1;
            end
            S_FIN: begin
                if (r_ok) begin
                    n_good = r_good + 1'b1;
                    n_fill = '0;
                    n_out.frame_valid = 1'b1;
                    n_out.frame_arrival_ms = r_ms;
                    n_state = S_OUT;
                end else begin
                    n_bad = r_bad + 1'b1;
                    n_out = '0;
                    n_idx = (AW+1)'(1);
                    n_src = '0;
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                // find lowest s in 1..30 with byte[s]==hf and byte[s+1]==hs
                raddr = r_idx[AW-1:0];
                if (r_idx != 1) begin
                    if (r_prev == r_hf && rdata == r_hs && rpos >= 2 && r_src == '0)
                        n_src = rpos - 1'b1;
                    n_prev = rdata;
                end
                if (r_idx == (AW+1)'(FRAME_BYTES)) n_state = S_SRCH2;
                else n_idx = r_idx + 1'b1;
            end
            S_SRCH2: begin
                if (r_src == '0) begin
                    if (r_prev == r_hf) begin
                        we = 1'b1; waddr = '0; wdata = r_hf;
                        n_fill = (AW+1)'(1);
                    end else begin
                        n_fill = '0;
                    end
                    n_state = S_OUT;
                end else begin
                    n_fill = (AW+1)'(FRAME_BYTES) - r_src;
                    n_idx = r_src;
                    n_dst = '0;
                    n_state = S_MOVE;
                end
            end
            S_MOVE: begin
                raddr = r_idx[AW-1:0];
                n_state = S_MOVE2;
            end
            S_MOVE2: begin
                we = 1'b1; waddr = r_dst[AW-1:0]; wdata = rdata;
                n_dst = r_dst + 1'b1;
                if (r_idx == (AW+1)'(FRAME_BYTES - 1)) begin
                    n_state = S_OUT;
                end else begin
                    n_idx = r_idx + 1'b1;
                    n_state = S_MOVE;
                end
            end
            S_OUT: begin
                if (!r_ov) begin
                    n_out.good_count = r_good;
                    n_out.bad_count = r_bad;
                    n_ov = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill <= '0; r_good <= '0; r_bad <= '0; r_ov <= 1'b0;
            r_hf <= '0; r_hs <= '0; r_ver <= '0; r_cmd <= '0;
        end else begin
            r_state <= n_state;
            r_fill <= n_fill; r_good <= n_good; r_bad <= n_bad; r_ov <= n_ov;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_HDR_FIRST:  r_hf <= i_cfg_data;
                    REG_HDR_SECOND: r_hs <= i_cfg_data;
                    REG_VERSION:    r_ver <= i_cfg_data;
                    REG_CMD_TYPE:   r_cmd <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx; r_src <= n_src; r_dst <= n_dst; r_crc <= n_crc;
        r_prev <= n_prev; r_ok <= n_ok; r_ms <= n_ms; r_out <= n_out;
        r_word <= n_word;
    end
endmodule
`default_nettype wire

// File: design/cfcp_checker.sv
// ----------------------------------------------------------------------------
// cfcp_checker
// Port-level checks for the framed command parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module cfcp_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_in_valid,
    input wire                 o_in_stall,
    input wire                 o_out_valid,
    input wire                 i_out_stall,
    input wire cfcp_pkg::t_out o_out
);
    import cfcp_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("output beat changed under stall");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while result pending");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.frame_valid |-> o_out.sequence_no == '0 &&
        o_out.frame_arrival_ms == '0)
        else $error("fields not zero without frame");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after a byte beat");
endmodule

bind crc_framed_command_parser_top cfcp_checker u_cfcp_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
    .o_in_stall(o_in_stall), .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall), .o_out(o_out)
);
`default_nettype wire
